/* design/wrbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbs_pkg: shared types and constants for the weighted random branch select
// Status codes, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package wrbs_pkg;

  localparam int DEFAULT_MAX_BRANCHES = 32;
  localparam int SPACE_W = 48;
  localparam int RAND_W  = 64;
  localparam int IDX_W   = 5;
  localparam int BITCNT_W = $clog2(RAND_W);

  localparam logic [1:0] STAT_CHOSEN = 2'd0;
  localparam logic [1:0] STAT_ENOENT = 2'd1;
  localparam logic [1:0] STAT_ENOSPC = 2'd2;
  localparam logic [1:0] STAT_EROFS  = 2'd3;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_DIV,
    S_WALK_RD,
    S_WALK_CHK,
    S_DONE
  } wrbs_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic walk_chk;
    logic push;
  } wrbs_cmd_t;

  typedef struct packed {
    logic in_last;
    logic empty_group;
    logic div_last;
    logic walk_stop;
    logic out_busy;
  } wrbs_sts_t;

endpackage

/* design/wrbs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbs_ctrl: sequencing controller
// Accepts records, then steps the datapath through modulo, weight walk and
// result hand-off; a group with no writable weight skips to hand-off.
// ----------------------------------------------------------------------------
module wrbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrbs_pkg::wrbs_sts_t sts,
  output wrbs_pkg::wrbs_cmd_t cmd
);
  import wrbs_pkg::*;

  wrbs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid && sts.in_last) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = sts.empty_group ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        state_next = sts.walk_stop ? S_DONE : S_WALK_RD;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SETUP:    cmd.setup    = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_WALK_RD:  cmd          = '0;
      S_WALK_CHK: cmd.walk_chk = 1'b1;
      S_DONE:     cmd.push     = !sts.out_busy;
      default:    cmd          = '0;
    endcase
  end

  a_div_to_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_last) |=> (state == S_WALK_RD))
    else $error("modulo did not hand over to weight walk");

  a_push_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (state == S_LOAD && in_ready))
    else $error("controller not back to loading after result");

endmodule

/* design/wrbs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbs_datapath: record accumulation, modulo and weight walk
// Holds the weight and index memories, group totals, a bit-serial remainder
// unit and the output register.
// ----------------------------------------------------------------------------
module wrbs_datapath #(
  parameter int MAX_BRANCHES = wrbs_pkg::DEFAULT_MAX_BRANCHES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wrbs_pkg::wrbs_cmd_t           cmd,
  output wrbs_pkg::wrbs_sts_t           sts,
  input  logic                          branch_read_only,
  input  logic                          parent_exists,
  input  logic                          info_ok,
  input  logic                          fs_read_only,
  input  logic [wrbs_pkg::SPACE_W-1:0]  space_avail,
  input  logic [wrbs_pkg::SPACE_W-1:0]  min_free_space,
  input  logic [wrbs_pkg::RAND_W-1:0]   random_value,
  input  logic                          last_branch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [wrbs_pkg::IDX_W-1:0]    chosen_index,
  output logic                          overflow
);
  import wrbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_BRANCHES + 1);
  localparam int AW    = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
  localparam int SUM_W = SPACE_W + $clog2(MAX_BRANCHES);

  logic [CNT_W-1:0]   rec_cnt;
  logic [CNT_W-1:0]   wr_cnt;
  logic [SUM_W-1:0]   wsum;
  logic [1:0]         merged;
  logic               ovf;
  logic [IDX_W-1:0]   last_pos;
  logic [IDX_W-1:0]   sel_idx;
  logic [RAND_W-1:0]  quo;
  logic [SUM_W-1:0]   rem;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]   walk_idx;
  logic [SUM_W-1:0]   run;

  logic [SPACE_W-1:0] weight_mem [MAX_BRANCHES];
  logic [IDX_W-1:0]   index_mem  [MAX_BRANCHES];
  logic [SPACE_W-1:0] rd_w;
  logic [IDX_W-1:0]   rd_idx;

  logic               room;
  logic               writable;
  logic [1:0]         rec_err;
  logic [SUM_W:0]     trial;
  logic [SUM_W:0]     trial_sub;
  logic               trial_ge;
  logic [SUM_W-1:0]   run_next;
  logic [CNT_W-1:0]   walk_nxt;
  logic               hit;
  logic               walk_end;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_idx;

  assign room = (rec_cnt != CNT_W'(MAX_BRANCHES));

  always_comb begin
    writable = 1'b0;
    rec_err  = STAT_ENOENT;
    if (branch_read_only) begin
      rec_err = STAT_EROFS;
    end else if (!parent_exists || !info_ok) begin
      rec_err = STAT_ENOENT;
    end else if (fs_read_only) begin
      rec_err = STAT_EROFS;
    end else if (space_avail < min_free_space) begin
      rec_err = STAT_ENOSPC;
    end else begin
      writable = 1'b1;
    end
  end

  assign trial     = {rem, quo[RAND_W-1]};
  assign trial_ge  = (trial >= {1'b0, wsum});
  assign trial_sub = trial - {1'b0, wsum};

  assign run_next = run + SUM_W'(rd_w);
  assign hit      = (rd_w != '0) && (run_next > rem);
  assign walk_nxt = walk_idx + CNT_W'(1);
  assign walk_end = (walk_nxt == wr_cnt);

  always_comb begin
    res_idx = '0;
    if (wr_cnt == '0) begin
      res_status = merged;
    end else if (wsum == '0) begin
      res_status = STAT_ENOSPC;
    end else begin
      res_status = STAT_CHOSEN;
      res_idx    = sel_idx;
    end
  end

  always_comb begin
    sts.in_last     = last_branch;
    sts.empty_group = (wr_cnt == '0) || (wsum == '0);
    sts.div_last    = (bit_cnt == BITCNT_W'(RAND_W - 1));
    sts.walk_stop   = hit || walk_end;
    sts.out_busy    = out_valid && !out_ready;
  end

  // group totals and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_cnt   <= '0;
      wr_cnt    <= '0;
      wsum      <= '0;
      merged    <= STAT_ENOENT;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (room) begin
          rec_cnt <= rec_cnt + CNT_W'(1);
          if (writable) begin
            wr_cnt <= wr_cnt + CNT_W'(1);
            wsum   <= wsum + SUM_W'(space_avail);
          end else if (rec_err > merged) begin
            merged <= rec_err;
          end
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.push) begin
        rec_cnt   <= '0;
        wr_cnt    <= '0;
        wsum      <= '0;
        merged    <= STAT_ENOENT;
        ovf       <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // remainder unit, weight walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= random_value;
      if (room && writable) last_pos <= IDX_W'(rec_cnt);
    end
    if (cmd.setup) begin
      rem      <= '0;
      bit_cnt  <= '0;
      walk_idx <= '0;
      run      <= '0;
    end
    if (cmd.div_step) begin
      rem     <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
      quo     <= {quo[RAND_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BITCNT_W'(1);
    end
    if (cmd.walk_chk) begin
      run      <= run_next;
      walk_idx <= walk_nxt;
      if (hit) begin
        sel_idx <= rd_idx;
      end else if (walk_end) begin
        sel_idx <= last_pos;
      end
    end
    if (cmd.push) begin
      status       <= res_status;
      chosen_index <= res_idx;
      overflow     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room && writable) begin
      weight_mem[wr_cnt[AW-1:0]] <= space_avail;
      index_mem[wr_cnt[AW-1:0]]  <= IDX_W'(rec_cnt);
    end
    rd_w   <= weight_mem[walk_idx[AW-1:0]];
    rd_idx <= index_mem[walk_idx[AW-1:0]];
  end

  a_sum_empty: assert property (@(posedge clk) disable iff (rst)
    (wr_cnt == '0) |-> (wsum == '0))
    else $error("weight sum nonzero with no writable branch");

  a_cnt_order: assert property (@(posedge clk) disable iff (rst)
    wr_cnt <= rec_cnt)
    else $error("writable count exceeds record count");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < wsum))
    else $error("partial remainder not below weight sum");

endmodule

/* design/weighted_random_branch_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_random_branch_select: roulette-wheel choice over writable branches
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | branch flags, space, min free, random, last
//   output  | out_valid / out_ready| status, chosen_index, overflow
//
// A record that is not marked last is taken in the loading state. A last record
// with no writable weight goes straight to hand-off; else a one-bit-per-cycle
// remainder over the 64-bit random word is followed by a walk over the stored
// weights, with a read and a check state per entry, until a hit or the end.
// Reset is synchronous and needs no memory sweep. Records are taken while an
// earlier result waits on out_ready; a stalled result holds only the final
// hand-off state.
// ----------------------------------------------------------------------------
module weighted_random_branch_select #(
  parameter int MAX_BRANCHES = wrbs_pkg::DEFAULT_MAX_BRANCHES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          branch_read_only,
  input  logic                          parent_exists,
  input  logic                          info_ok,
  input  logic                          fs_read_only,
  input  logic [wrbs_pkg::SPACE_W-1:0]  space_avail,
  input  logic [wrbs_pkg::SPACE_W-1:0]  min_free_space,
  input  logic [wrbs_pkg::RAND_W-1:0]   random_value,
  input  logic                          last_branch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [wrbs_pkg::IDX_W-1:0]    chosen_index,
  output logic                          overflow
);
  import wrbs_pkg::*;

  wrbs_cmd_t cmd;
  wrbs_sts_t sts;

  wrbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrbs_datapath #(
    .MAX_BRANCHES (MAX_BRANCHES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .branch_read_only (branch_read_only),
    .parent_exists    (parent_exists),
    .info_ok          (info_ok),
    .fs_read_only     (fs_read_only),
    .space_avail      (space_avail),
    .min_free_space   (min_free_space),
    .random_value     (random_value),
    .last_branch      (last_branch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .chosen_index     (chosen_index),
    .overflow         (overflow)
  );

endmodule

/* test/tb_weighted_random_branch_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_random_branch_select: self-checking bench for the branch select
// Sends groups of branch records over the input channel, predicts the status,
// chosen branch and overflow flag of every group from its own roulette-wheel
// model, or the table for typed rows, and compares each output transaction
// in order. A short directed table covers flag and space extremes and error
// priorities; random groups of mostly writable branches follow, with overflow
// groups, bursty input, patterned output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_weighted_random_branch_select;
  import wrbs_pkg::*;

  localparam int NUM_BR      = DEFAULT_MAX_BRANCHES;
  localparam int N_ITEMS     = 1750;
  localparam int WDOG_LIMIT  = 4000;
  localparam int HOLD_CYC    = 500;
  localparam int DRAIN_CYC   = 200;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                ro;
    logic                parent;
    logic                info;
    logic                fsro;
    logic [SPACE_W-1:0]  avail;
    logic [SPACE_W-1:0]  minfree;
    logic [RAND_W-1:0]   rnd;
    logic                last;
  } branch_rec_t;

  typedef struct packed {
    logic [1:0]       st;
    logic [IDX_W-1:0] idx;
    logic             ovf;
  } sel_res_t;

  typedef struct packed {
    branch_rec_t rec;
    logic        typed;
    sel_res_t    res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               branch_read_only = 1'b0;
  logic               parent_exists = 1'b0;
  logic               info_ok = 1'b0;
  logic               fs_read_only = 1'b0;
  logic [SPACE_W-1:0] space_avail = '0;
  logic [SPACE_W-1:0] min_free_space = '0;
  logic [RAND_W-1:0]  random_value = '0;
  logic               last_branch = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [IDX_W-1:0]   chosen_index;
  logic               overflow;

  weighted_random_branch_select DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .branch_read_only (branch_read_only),
    .parent_exists    (parent_exists),
    .info_ok          (info_ok),
    .fs_read_only     (fs_read_only),
    .space_avail      (space_avail),
    .min_free_space   (min_free_space),
    .random_value     (random_value),
    .last_branch      (last_branch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .chosen_index     (chosen_index),
    .overflow         (overflow)
  );

  always #2 clk = ~clk;

  // selection model state
  logic [SPACE_W-1:0] wt_mem  [NUM_BR];
  logic [IDX_W-1:0]   pos_mem [NUM_BR];
  int unsigned        n_writable = 0;
  int unsigned        n_records = 0;
  logic [52:0]        wt_total = '0;
  logic [1:0]         worst_err = STAT_ENOENT;
  logic               ovf_seen = 1'b0;

  sel_res_t    sel_q[$];
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned stall_cyc = 0;
  int unsigned burst_left = 1;

  function automatic void fold_err(input logic [1:0] e);
    if (e > worst_err) worst_err = e;
  endfunction

  function automatic bit select_branch(input branch_rec_t r, output sel_res_t res);
    logic [RAND_W-1:0] thr;
    logic [RAND_W-1:0] run;
    bit                found;
    res = '0;
    if (n_records >= NUM_BR) begin
      ovf_seen = 1'b1;
    end else begin
      if (r.ro) begin
        fold_err(STAT_EROFS);
      end else if (!r.parent || !r.info) begin
        fold_err(STAT_ENOENT);
      end else if (r.fsro) begin
        fold_err(STAT_EROFS);
      end else if (r.avail < r.minfree) begin
        fold_err(STAT_ENOSPC);
      end else begin
        wt_mem[n_writable]  = r.avail;
        pos_mem[n_writable] = IDX_W'(n_records);
        n_writable++;
        wt_total += 53'(r.avail);
      end
      n_records++;
    end
    if (!r.last) return 1'b0;
    res.st  = STAT_CHOSEN;
    res.ovf = ovf_seen;
    if (n_writable == 0) begin
      res.st = worst_err;
    end else if (wt_total == 0) begin
      res.st = STAT_ENOSPC;
    end else begin
      thr   = r.rnd % RAND_W'(wt_total);
      run   = '0;
      found = 1'b0;
      for (int i = 0; i < n_writable; i++) begin
        if (!found && wt_mem[i] != 0) begin
          run += RAND_W'(wt_mem[i]);
          if (run > thr) begin
            found   = 1'b1;
            res.idx = pos_mem[i];
          end
        end
      end
      if (!found) res.idx = pos_mem[n_writable-1];
    end
    n_writable = 0;
    n_records  = 0;
    wt_total   = '0;
    worst_err  = STAT_ENOENT;
    ovf_seen   = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SPACE_W-1:0] rand_space();
    logic [63:0] w;
    int unsigned m;
    w = {$urandom, $urandom};
    m = $urandom_range(0, 9);
    case (m)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return SPACE_W'($urandom_range(0, 1000));
      default: return w[SPACE_W-1:0];
    endcase
  endfunction

  task automatic offer(input branch_rec_t r, input logic typed, input sel_res_t typed_res);
    sel_res_t pred;
    in_valid         <= 1'b1;
    branch_read_only <= r.ro;
    parent_exists    <= r.parent;
    info_ok          <= r.info;
    fs_read_only     <= r.fsro;
    space_avail      <= r.avail;
    min_free_space   <= r.minfree;
    random_value     <= r.rnd;
    last_branch      <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    if (select_branch(r, pred)) sel_q.insert(sel_q.size(), typed ? typed_res : pred);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (sel_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
          $display("unexpected transaction: status %0d index %0d overflow %0d",
                   status, chosen_index, overflow);
      end else begin
        if (status !== sel_q[0].st || chosen_index !== sel_q[0].idx ||
            overflow !== sel_q[0].ovf) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("mismatch: status %0d/%0d index %0d/%0d overflow %0d/%0d (exp/got)",
                     sel_q[0].st, status, sel_q[0].idx, chosen_index,
                     sel_q[0].ovf, overflow);
        end
        void'(sel_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cyc <= 0;
    end else if (stall_cyc >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  // output side: rotating stall patterns plus one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned hold;
    bit          held;
    cyc  = 0;
    hold = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!held && sent_cnt >= 400) begin
        held      = 1'b1;
        hold      = HOLD_CYC;
        out_ready <= 1'b0;
      end else begin
        case ((cyc >> 8) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cyc % 7) != 3);
        endcase
      end
      cyc++;
      @(posedge clk);
    end
  end

  initial begin
    dir_row_t    dir_tbl [22];
    branch_rec_t rec;
    int unsigned gsize;
    int unsigned pick;
    int unsigned grp;
    dir_tbl = '{
      '{'{1'b1, 1'b0, 1'b0, 1'b1, 48'd0, 48'd0, 64'd0, 1'b1}, 1'b1,
        '{STAT_EROFS, 5'd0, 1'b0}},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 48'd100, 48'd0, 64'd0, 1'b1}, 1'b1,
        '{STAT_ENOENT, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 48'd100, 48'd0, 64'd0, 1'b1}, 1'b1,
        '{STAT_ENOENT, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b1, 48'd100, 48'd0, 64'd0, 1'b1}, 1'b1,
        '{STAT_EROFS, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd0, 48'd1, 64'd0, 1'b1}, 1'b1,
        '{STAT_ENOSPC, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd0, 48'd0, '1, 1'b1}, 1'b1,
        '{STAT_ENOSPC, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, '1, '1, '1, 1'b1}, 1'b1,
        '{STAT_CHOSEN, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd1, 48'd0, 64'd0, 1'b1}, 1'b1,
        '{STAT_CHOSEN, 5'd0, 1'b0}},
      '{'{1'b1, 1'b1, 1'b1, 1'b0, 48'd5, 48'd0, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd4, 48'd9, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 48'd5, 48'd0, 64'd0, 1'b1}, 1'b1,
        '{STAT_EROFS, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 48'd5, 48'd0, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd2, 48'd3, 64'd0, 1'b1}, 1'b1,
        '{STAT_ENOSPC, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd0, 48'd0, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd5, 48'd5, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b1, 1'b0, 1'b0, 1'b0, 48'd7, 48'd0, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'd3, 48'd0, 64'd7, 1'b1}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, '1, 48'd0, 64'd0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, '1, '1, '1, 1'b1}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b1, 48'd0, '1, '1, 1'b1}, 1'b1,
        '{STAT_EROFS, 5'd0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'h8000_0000_0001, 48'h0000_0000_FFFF,
          64'h5555_AAAA_0F0F_F0F0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 1'b1, 1'b1, 1'b0, 48'h0000_1234_5678, 48'h0000_1234_5678,
          64'hDEAD_BEEF_0123_4567, 1'b1}, 1'b0, '0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) offer(dir_tbl[i].rec, dir_tbl[i].typed, dir_tbl[i].res);

    grp = 0;
    while (sent_cnt < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (grp == 0)       gsize = 36;
      else if (pick < 70) gsize = $urandom_range(1, 8);
      else if (pick < 85) gsize = $urandom_range(9, 30);
      else if (pick < 93) gsize = $urandom_range(31, 32);
      else                gsize = $urandom_range(33, 40);
      for (int k = 0; k < gsize; k++) begin
        if ($urandom_range(0, 99) < 78) begin
          {rec.ro, rec.parent, rec.info, rec.fsro} = 4'b0110;
          rec.avail   = rand_space();
          rec.minfree = rec.avail & rand_space();
        end else begin
          {rec.ro, rec.parent, rec.info, rec.fsro} = 4'($urandom);
          rec.avail   = rand_space();
          rec.minfree = rand_space();
        end
        if ($urandom_range(0, 19) == 0)
          rec.rnd = $urandom_range(0, 1) ? '1 : '0;
        else
          rec.rnd = {$urandom, $urandom};
        rec.last = (k == gsize - 1);
        offer(rec, 1'b0, '0);
      end
      grp++;
    end
    in_valid <= 1'b0;

    while (sel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
